// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons holds at the same edge.
`define ASSERT_IMP(name, clock, reset_n, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!(reset_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define ASSERT_NEXT(name, clock, reset_n, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!(reset_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define ASSERT_IMP(name, clock, reset_n, ante, cons)
`define ASSERT_NEXT(name, clock, reset_n, ante, cons)

`endif

`endif

// ===== sv/ffc_pkg.sv =====
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared types, constants and helper functions of the free-fly camera update.
// ----------------------------------------------------------------------------
`default_nettype none

package ffc_pkg;

    // Field widths.
    localparam int POS_W      = 32;
    localparam int ANG_W      = 16;
    localparam int CMD_W      = 4;
    localparam int TIME_W     = 16;
    localparam int MOVE_W     = 16;
    localparam int TURN_W     = 24;
    localparam int RATE_W     = MOVE_W + TIME_W;
    localparam int TURN_LSB   = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Default parameter values.
    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int POS_FRAC_BITS_DEF = 16;

    // Datapath widths.
    localparam int CORDIC_W = 34;
    localparam int FAC_W    = 18;
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = FAC_W;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int TRIG_SH  = 15;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // Configuration reset values.
    localparam logic [MOVE_W-1:0] MOVE_SPEED_RST = 16'd256;
    localparam logic [TURN_W-1:0] TURN_SPEED_RST = 24'd65536;

    // Arctangent table, unsigned Q0.32 turns, so that a full turn is 2^32.
    localparam int ATAN_N     = 24;
    localparam int ATAN_IDX_W = $clog2(ATAN_N);
    localparam logic [31:0] ATAN_TAB [0:ATAN_N-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_LEFT       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_RIGHT      = 4'd2;
    localparam logic [CMD_W-1:0] CMD_BACK       = 4'd3;
    localparam logic [CMD_W-1:0] CMD_FORWARD    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DOWN       = 4'd5;
    localparam logic [CMD_W-1:0] CMD_UP         = 4'd6;
    localparam logic [CMD_W-1:0] CMD_TURN_LEFT  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_TURN_RIGHT = 4'd8;
    localparam logic [CMD_W-1:0] CMD_TURN_DOWN  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_TURN_UP    = 4'd10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PITCH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_YAW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SPEED  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_SPEED  = 3'd6;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_RATE_USE,
        S_CORDIC,
        S_TRIG_END,
        S_MUL,
        S_ACC,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    // Multiplier operand sources.
    typedef enum logic [2:0] {
        OPD_DIST,
        OPD_SIN_YAW,
        OPD_COS_YAW,
        OPD_SIN_PITCH,
        OPD_COS_PITCH,
        OPD_FAC
    } opnd_t;

    localparam int MV_STEP_W = 3;
    localparam logic [MV_STEP_W-1:0] MV_STEP_MAX = 3'd4;

    // One multiply-and-use step of a translation.
    typedef struct packed {
        logic  to_fac;
        axis_t axis;
        logic  neg;
        logic  last;
        opnd_t a_sel;
        opnd_t b_sel;
    } mv_op_t;

    // Step list of the horizontal moves. Strafing scales the yaw vector
    // directly; forward and back first form the pitch-weighted factors.
    function automatic mv_op_t mv_decode(input logic [CMD_W-1:0] cmd,
                                         input logic [MV_STEP_W-1:0] step);
        mv_op_t op;
        logic   fwd;
        op.to_fac = 1'b0;
        op.axis   = AX_X;
        op.neg    = 1'b0;
        op.last   = 1'b0;
        op.a_sel  = OPD_DIST;
        op.b_sel  = OPD_COS_YAW;
        fwd = (cmd == CMD_BACK) || (cmd == CMD_FORWARD);
        if (!fwd)
        begin
            case (step)
                3'd0:
                begin
                    op.b_sel = OPD_COS_YAW;
                    op.axis  = AX_X;
                    op.neg   = (cmd == CMD_LEFT);
                end
                default:
                begin
                    op.b_sel = OPD_SIN_YAW;
                    op.axis  = AX_Z;
                    op.neg   = (cmd == CMD_RIGHT);
                    op.last  = 1'b1;
                end
            endcase
        end
        else
        begin
            case (step)
                3'd0:
                begin
                    op.to_fac = 1'b1;
                    op.a_sel  = OPD_SIN_YAW;
                    op.b_sel  = OPD_COS_PITCH;
                end
                3'd1:
                begin
                    op.b_sel = OPD_FAC;
                    op.axis  = AX_X;
                    op.neg   = (cmd == CMD_FORWARD);
                end
                3'd2:
                begin
                    op.to_fac = 1'b1;
                    op.a_sel  = OPD_COS_YAW;
                    op.b_sel  = OPD_COS_PITCH;
                end
                3'd3:
                begin
                    op.b_sel = OPD_FAC;
                    op.axis  = AX_Z;
                    op.neg   = (cmd == CMD_FORWARD);
                end
                default:
                begin
                    op.b_sel = OPD_SIN_PITCH;
                    op.axis  = AX_Y;
                    op.neg   = (cmd == CMD_BACK);
                    op.last  = 1'b1;
                end
            endcase
        end
        return op;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ffc_if.sv =====
// ----------------------------------------------------------------------------
// ffc_if
// Valid/ready channel interfaces: camera commands in, camera poses out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffc_cmd_if;
    import ffc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [TIME_W-1:0]   time_step;

    modport source (output valid, output command, output time_step, input ready);
    modport sink   (input valid, input command, input time_step, output ready);
endinterface

interface ffc_pose_if;
    import ffc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x_out;
    logic signed [POS_W-1:0] pos_y_out;
    logic signed [POS_W-1:0] pos_z_out;
    logic [ANG_W-1:0]        yaw_out;
    logic [ANG_W-1:0]        pitch_out;
    logic                    saturated;

    modport source (output valid, output pos_x_out, output pos_y_out, output pos_z_out,
                    output yaw_out, output pitch_out, output saturated, input ready);
    modport sink   (input valid, input pos_x_out, input pos_y_out, input pos_z_out,
                    input yaw_out, input pitch_out, input saturated, output ready);
endinterface

`default_nettype wire

// ===== sv/free_fly_camera_update.sv =====
// ----------------------------------------------------------------------------
// free_fly_camera_update
// Fixed-point free-fly camera: keeps position and yaw/pitch, applies one
// move or turn command per transaction and returns the new pose.
// ----------------------------------------------------------------------------
// The block takes one command transaction at a time and answers each with
// exactly one pose transaction. Work runs through a small sequencer around
// one multiplier and one CORDIC rotation stage. Load, turn, up, down and
// unused codes need only the speed-time multiply; strafing left or right
// adds one sine/cosine pass of the CORDIC stage and two multiply steps, and
// moving forward or back adds two CORDIC passes and five multiply steps.
// The pose sits in an output register, so a new command is accepted while
// the previous pose still waits to be taken; the block only stalls at the
// end of a command if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module free_fly_camera_update #(
    parameter int CORDIC_STEPS  = ffc_pkg::CORDIC_STEPS_DEF,
    parameter int POS_FRAC_BITS = ffc_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ffc_cmd_if.sink                            cmd_ch,
    ffc_pose_if.source                         pose_ch,
    input  logic                               cfg_we,
    input  logic [ffc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ffc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ffc_pkg::*;

    // Iteration counter of the CORDIC stage.
    localparam int ITER_W = $clog2(CORDIC_STEPS);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

    // The speed-time product has 20 fraction bits. With fewer position
    // fraction bits it is cut down before the multiply; with more, the
    // extra left shift is folded into a shorter right shift after it.
    localparam int RSH    = (POS_FRAC_BITS <= 20) ? 20 - POS_FRAC_BITS : 0;
    localparam int LSH    = (POS_FRAC_BITS > 20) ? POS_FRAC_BITS - 20 : 0;
    localparam int SCL_SH = TRIG_SH - LSH;
    localparam int DIST_W = RATE_W + LSH;
    localparam int DLT_W  = PROD_W + 1;
    localparam int SUM_W  = DLT_W + 1;

    // Sequencer.
    state_t state_reg;
    state_t state_next;

    // Command being worked on.
    logic [CMD_W-1:0]  cmd_reg;
    logic [TIME_W-1:0] time_reg;

    // Configuration registers.
    logic signed [POS_W-1:0] start_x_reg;
    logic signed [POS_W-1:0] start_y_reg;
    logic signed [POS_W-1:0] start_z_reg;
    logic [ANG_W-1:0]        start_pitch_reg;
    logic [ANG_W-1:0]        start_yaw_reg;
    logic [MOVE_W-1:0]       move_speed_reg;
    logic [TURN_W-1:0]       turn_speed_reg;

    // Camera pose.
    logic signed [POS_W-1:0] pos_x_reg;
    logic signed [POS_W-1:0] pos_y_reg;
    logic signed [POS_W-1:0] pos_z_reg;
    logic [ANG_W-1:0]        yaw_reg;
    logic [ANG_W-1:0]        pitch_reg;
    logic                    sat_reg;

    // Shared multiplier and its result register.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_out;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [RATE_W-1:0]         rate_reg;

    // CORDIC stage.
    logic signed [CORDIC_W-1:0] cdx_reg;
    logic signed [CORDIC_W-1:0] cdy_reg;
    logic signed [CORDIC_W-1:0] cdz_reg;
    logic                       cneg_reg;
    logic [ITER_W-1:0]          iter_reg;
    logic                       pass_reg;
    logic signed [CORDIC_W-1:0] cd_xs;
    logic signed [CORDIC_W-1:0] cd_ys;
    logic [ATAN_IDX_W-1:0]      atan_idx;
    logic signed [CORDIC_W-1:0] atan_val;
    logic [ANG_W-1:0]           cd_ang;
    logic                       cd_fold;
    logic [31:0]                cd_z0;
    logic signed [CORDIC_W-1:0] cd_x_fin;
    logic signed [CORDIC_W-1:0] cd_y_fin;
    logic signed [CORDIC_W-1:0] cd_x_sh;
    logic signed [CORDIC_W-1:0] cd_y_sh;

    // Sine and cosine of both angles, Q15, and the product factor.
    logic signed [FAC_W-1:0] sin_yaw_reg;
    logic signed [FAC_W-1:0] cos_yaw_reg;
    logic signed [FAC_W-1:0] sin_pitch_reg;
    logic signed [FAC_W-1:0] cos_pitch_reg;
    logic signed [FAC_W-1:0] fac_reg;
    logic signed [PROD_W-1:0] fac_sh;

    // Move step list.
    logic [MV_STEP_W-1:0] step_reg;
    mv_op_t               mv_op;

    // Saturating position adder.
    logic [DIST_W-1:0]        move_dist;
    logic signed [PROD_W-1:0] scl;
    logic signed [DLT_W-1:0]  mag_scl;
    logic signed [DLT_W-1:0]  mag_dist;
    logic signed [DLT_W-1:0]  mag;
    logic signed [DLT_W-1:0]  delta;
    logic                     wr_neg;
    axis_t                    wr_axis;
    logic signed [POS_W-1:0]  pos_sel;
    logic signed [SUM_W-1:0]  add_sum;
    logic signed [POS_W-1:0]  clamp_val;
    logic                     clamp_hit;

    // Command classes.
    logic is_turn;
    logic is_move;
    logic is_vert;
    logic is_fwd;

    // Sequencer controls.
    logic in_acc;
    logic in_ready;
    logic out_free;
    logic out_load;
    logic cd_load;
    logic pos_wr;

    // Output register.
    logic                    out_valid_reg;
    logic signed [POS_W-1:0] pos_x_out_reg;
    logic signed [POS_W-1:0] pos_y_out_reg;
    logic signed [POS_W-1:0] pos_z_out_reg;
    logic [ANG_W-1:0]        yaw_out_reg;
    logic [ANG_W-1:0]        pitch_out_reg;
    logic                    saturated_reg;

    // ------------------------------------------------------------------
    // Command classification
    // ------------------------------------------------------------------
    assign is_turn = (cmd_reg >= CMD_TURN_LEFT) && (cmd_reg <= CMD_TURN_UP);
    assign is_move = (cmd_reg >= CMD_LEFT) && (cmd_reg <= CMD_UP);
    assign is_vert = (cmd_reg == CMD_DOWN) || (cmd_reg == CMD_UP);
    assign is_fwd  = (cmd_reg == CMD_BACK) || (cmd_reg == CMD_FORWARD);

    assign mv_op = mv_decode(cmd_reg, step_reg);

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_RATE;
                end
            end
            S_RATE:
            begin
                state_next = S_RATE_USE;
            end
            S_RATE_USE:
            begin
                if (is_move && !is_vert)
                begin
                    state_next = S_CORDIC;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CORDIC:
            begin
                if (iter_reg == ITER_LAST)
                begin
                    state_next = S_TRIG_END;
                end
            end
            S_TRIG_END:
            begin
                if (!pass_reg && is_fwd)
                begin
                    state_next = S_CORDIC;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (mv_op.last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        in_acc   = in_ready && cmd_ch.valid;
        out_free = !out_valid_reg || pose_ch.ready;
        out_load = (state_reg == S_DONE) && out_free;
        // The CORDIC stage starts on yaw for every horizontal move and
        // runs a second pass on pitch for forward and back.
        cd_load  = ((state_reg == S_RATE_USE) && is_move && !is_vert) ||
                   ((state_reg == S_TRIG_END) && !pass_reg && is_fwd);
        pos_wr   = ((state_reg == S_RATE_USE) && is_vert) ||
                   ((state_reg == S_ACC) && !mv_op.to_fac);
    end

    assign cmd_ch.ready = in_ready;

    // ------------------------------------------------------------------
    // Shared multiplier operands
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_RATE)
        begin
            // Speed times time step: distance for moves, angle for turns.
            if (is_turn)
            begin
                mul_a = MUL_A_W'(turn_speed_reg);
            end
            else
            begin
                mul_a = MUL_A_W'(move_speed_reg);
            end
            mul_b = MUL_B_W'(time_reg);
        end
        else
        begin
            case (mv_op.a_sel)
                OPD_SIN_YAW: mul_a = MUL_A_W'(sin_yaw_reg);
                OPD_COS_YAW: mul_a = MUL_A_W'(cos_yaw_reg);
                default:     mul_a = MUL_A_W'(rate_reg >> RSH);
            endcase
            case (mv_op.b_sel)
                OPD_SIN_YAW:   mul_b = sin_yaw_reg;
                OPD_COS_YAW:   mul_b = cos_yaw_reg;
                OPD_SIN_PITCH: mul_b = sin_pitch_reg;
                OPD_COS_PITCH: mul_b = cos_pitch_reg;
                default:       mul_b = fac_reg;
            endcase
        end
    end

    assign mul_out = mul_a * mul_b;

    // ------------------------------------------------------------------
    // CORDIC stage: one micro-rotation per cycle
    // ------------------------------------------------------------------
    assign cd_xs    = cdx_reg >>> iter_reg;
    assign cd_ys    = cdy_reg >>> iter_reg;
    assign atan_idx = ATAN_IDX_W'(iter_reg);
    assign atan_val = CORDIC_W'(ATAN_TAB[atan_idx]);

    // Angles in the left half-plane are turned by half a turn so the
    // rotation stays within its convergence range; the result is negated.
    assign cd_ang  = (state_reg == S_RATE_USE) ? yaw_reg : pitch_reg;
    assign cd_fold = cd_ang[ANG_W-1] ^ cd_ang[ANG_W-2];
    assign cd_z0   = {cd_ang[ANG_W-1] ^ cd_fold, cd_ang[ANG_W-2:0], 16'h0000};

    assign cd_x_fin = cneg_reg ? -cdx_reg : cdx_reg;
    assign cd_y_fin = cneg_reg ? -cdy_reg : cdy_reg;
    assign cd_x_sh  = cd_x_fin >>> TRIG_SH;
    assign cd_y_sh  = cd_y_fin >>> TRIG_SH;

    assign fac_sh = prod_reg >>> TRIG_SH;

    // ------------------------------------------------------------------
    // Saturating position adder
    // ------------------------------------------------------------------
    assign move_dist = (DIST_W'(prod_reg[RATE_W-1:0]) << LSH) >> RSH;
    assign scl      = prod_reg >>> SCL_SH;
    assign mag_scl  = DLT_W'(scl);
    assign mag_dist = DLT_W'(move_dist);
    assign mag      = (state_reg == S_ACC) ? mag_scl : mag_dist;
    assign wr_neg   = (state_reg == S_ACC) ? mv_op.neg : (cmd_reg == CMD_DOWN);
    assign wr_axis  = (state_reg == S_ACC) ? mv_op.axis : AX_Y;
    assign delta    = wr_neg ? -mag : mag;

    always_comb
    begin
        case (wr_axis)
            AX_Y:    pos_sel = pos_y_reg;
            AX_Z:    pos_sel = pos_z_reg;
            default: pos_sel = pos_x_reg;
        endcase
    end

    assign add_sum = SUM_W'(pos_sel) + SUM_W'(delta);

    always_comb
    begin
        clamp_hit = 1'b0;
        clamp_val = add_sum[POS_W-1:0];
        if (add_sum > SUM_W'(POS_MAX))
        begin
            clamp_hit = 1'b1;
            clamp_val = POS_MAX;
        end
        else if (add_sum < SUM_W'(POS_MIN))
        begin
            clamp_hit = 1'b1;
            clamp_val = POS_MIN;
        end
    end

    // ------------------------------------------------------------------
    // Control and architectural state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            start_z_reg     <= '0;
            start_pitch_reg <= '0;
            start_yaw_reg   <= '0;
            move_speed_reg  <= MOVE_SPEED_RST;
            turn_speed_reg  <= TURN_SPEED_RST;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            pos_z_reg       <= '0;
            yaw_reg         <= '0;
            pitch_reg       <= '0;
            sat_reg         <= 1'b0;
            iter_reg        <= '0;
            pass_reg        <= 1'b0;
            step_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pose_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_START_X:     start_x_reg     <= cfg_data[POS_W-1:0];
                    CFG_START_Y:     start_y_reg     <= cfg_data[POS_W-1:0];
                    CFG_START_Z:     start_z_reg     <= cfg_data[POS_W-1:0];
                    CFG_START_PITCH: start_pitch_reg <= cfg_data[ANG_W-1:0];
                    CFG_START_YAW:   start_yaw_reg   <= cfg_data[ANG_W-1:0];
                    CFG_MOVE_SPEED:  move_speed_reg  <= cfg_data[MOVE_W-1:0];
                    CFG_TURN_SPEED:  turn_speed_reg  <= cfg_data[TURN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_acc)
            begin
                sat_reg <= 1'b0;
            end
            else if (pos_wr && clamp_hit)
            begin
                sat_reg <= 1'b1;
            end

            if ((state_reg == S_RATE_USE) && (cmd_reg == CMD_LOAD))
            begin
                pos_x_reg <= start_x_reg;
                pos_y_reg <= start_y_reg;
                pos_z_reg <= start_z_reg;
                yaw_reg   <= start_yaw_reg;
                pitch_reg <= start_pitch_reg;
            end
            else if (pos_wr)
            begin
                case (wr_axis)
                    AX_Y:    pos_y_reg <= clamp_val;
                    AX_Z:    pos_z_reg <= clamp_val;
                    default: pos_x_reg <= clamp_val;
                endcase
            end

            // Turns use the whole-unit part of the turn product, mod 2^16.
            if ((state_reg == S_RATE_USE) && is_turn)
            begin
                unique case (cmd_reg)
                    CMD_TURN_LEFT:  yaw_reg   <= yaw_reg + prod_reg[TURN_LSB +: ANG_W];
                    CMD_TURN_RIGHT: yaw_reg   <= yaw_reg - prod_reg[TURN_LSB +: ANG_W];
                    CMD_TURN_DOWN:  pitch_reg <= pitch_reg - prod_reg[TURN_LSB +: ANG_W];
                    default:        pitch_reg <= pitch_reg + prod_reg[TURN_LSB +: ANG_W];
                endcase
            end

            if (cd_load)
            begin
                iter_reg <= '0;
                pass_reg <= (state_reg == S_TRIG_END);
            end
            else if (state_reg == S_CORDIC)
            begin
                iter_reg <= iter_reg + 1'b1;
            end

            if (state_reg == S_TRIG_END)
            begin
                step_reg <= '0;
            end
            else if (state_reg == S_ACC)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg  <= cmd_ch.command;
            time_reg <= cmd_ch.time_step;
        end

        if ((state_reg == S_RATE) || (state_reg == S_MUL))
        begin
            prod_reg <= mul_out;
        end

        if (state_reg == S_RATE_USE)
        begin
            rate_reg <= prod_reg[RATE_W-1:0];
        end

        if (cd_load)
        begin
            cdx_reg  <= CORDIC_GAIN;
            cdy_reg  <= '0;
            cdz_reg  <= CORDIC_W'($signed(cd_z0));
            cneg_reg <= cd_fold;
        end
        else if (state_reg == S_CORDIC)
        begin
            if (!cdz_reg[CORDIC_W-1])
            begin
                cdx_reg <= cdx_reg - cd_ys;
                cdy_reg <= cdy_reg + cd_xs;
                cdz_reg <= cdz_reg - atan_val;
            end
            else
            begin
                cdx_reg <= cdx_reg + cd_ys;
                cdy_reg <= cdy_reg - cd_xs;
                cdz_reg <= cdz_reg + atan_val;
            end
        end

        if (state_reg == S_TRIG_END)
        begin
            if (!pass_reg)
            begin
                sin_yaw_reg <= cd_y_sh[FAC_W-1:0];
                cos_yaw_reg <= cd_x_sh[FAC_W-1:0];
            end
            else
            begin
                sin_pitch_reg <= cd_y_sh[FAC_W-1:0];
                cos_pitch_reg <= cd_x_sh[FAC_W-1:0];
            end
        end

        if ((state_reg == S_ACC) && mv_op.to_fac)
        begin
            fac_reg <= fac_sh[FAC_W-1:0];
        end

        if (out_load)
        begin
            pos_x_out_reg <= pos_x_reg;
            pos_y_out_reg <= pos_y_reg;
            pos_z_out_reg <= pos_z_reg;
            yaw_out_reg   <= yaw_reg;
            pitch_out_reg <= pitch_reg;
            saturated_reg <= sat_reg;
        end
    end

    assign pose_ch.valid     = out_valid_reg;
    assign pose_ch.pos_x_out = pos_x_out_reg;
    assign pose_ch.pos_y_out = pos_y_out_reg;
    assign pose_ch.pos_z_out = pos_z_out_reg;
    assign pose_ch.yaw_out   = yaw_out_reg;
    assign pose_ch.pitch_out = pitch_out_reg;
    assign pose_ch.saturated = saturated_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An accepted command always starts with the speed-time multiply.
    `ASSERT_NEXT(a_accept_starts_rate, clk, rst_n, cmd_ch.valid && cmd_ch.ready, state_reg == S_RATE)
    // Only translations can clip the position.
    `ASSERT_IMP(a_sat_only_on_move, clk, rst_n, (state_reg == S_DONE) && !is_move, !sat_reg)
    // A pose is only presented when the sequencer finishes a command.
    `ASSERT_IMP(a_pose_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == S_DONE)
    // The move step counter never runs past the longest step list.
    `ASSERT_IMP(a_step_bound, clk, rst_n, (state_reg == S_MUL) || (state_reg == S_ACC), step_reg <= MV_STEP_MAX)

endmodule

`default_nettype wire

// ===== dv/free_fly_camera_update_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_fly_camera_update_tb
// Self-checking bench for the fixed-point free-fly camera. Command
// transactions go in through a queue-fed driver, and a local model of the
// camera pose predicts every pose transaction that comes out. The bench
// runs a short directed sequence and then random phases, each with its own
// register setting, under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module free_fly_camera_update_tb;
    import ffc_pkg::*;

    // One command transaction as the bench queues it.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TIME_W-1:0] time_step;
    } cam_cmd_t;

    // One pose transaction, used for both predicted and observed poses.
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [ANG_W-1:0]        yaw;
        logic [ANG_W-1:0]        pitch;
        logic                    clipped;
    } cam_pose_t;

    // Codes 11 to 15 are not commands; the block must return the pose as is.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_TURN_UP + 4'd1;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

    localparam int N_RANDOM_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int CALM_PHASE      = 6;    // phase run with no idling at all
    localparam int IDLE_PERCENT    = 36;
    // No correct run goes this long without a transaction: the slowest
    // command and the random stalls both stay far shorter.
    localparam int STALL_LIMIT     = 4000;
    // Cycles to watch for stray poses once every expected pose has arrived.
    localparam int TAIL_CYCLES     = 100;
    localparam int MAX_REPORTS     = 100;

    // Rotation-mode CORDIC constants: start gain in Q2.30 and the arctangent
    // table scaled so that a full turn is 2^32.
    localparam int     N_ROT        = 16;
    localparam longint CORDIC_START = 64'sd652032874;
    localparam longint ATAN_Q32 [0:N_ROT-1] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
        'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
        'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D
    };
    localparam longint POS_HI = 64'sd2147483647;
    localparam longint POS_LO = -64'sd2147483648;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ffc_cmd_if  cmd_ch ();
    ffc_pose_if pose_ch ();

    free_fly_camera_update i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .pose_ch   (pose_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Register mirror, with the reset values of the block.
    logic signed [POS_W-1:0] reg_start_x     = '0;
    logic signed [POS_W-1:0] reg_start_y     = '0;
    logic signed [POS_W-1:0] reg_start_z     = '0;
    logic [ANG_W-1:0]        reg_start_pitch = '0;
    logic [ANG_W-1:0]        reg_start_yaw   = '0;
    logic [MOVE_W-1:0]       reg_move_speed  = 16'd256;
    logic [TURN_W-1:0]       reg_turn_speed  = 24'd65536;

    // Camera state as the model tracks it, zero after reset.
    logic signed [POS_W-1:0] cam_x     = '0;
    logic signed [POS_W-1:0] cam_y     = '0;
    logic signed [POS_W-1:0] cam_z     = '0;
    logic [ANG_W-1:0]        cam_yaw   = '0;
    logic [ANG_W-1:0]        cam_pitch = '0;

    cam_cmd_t  pending_q [$];      // commands not yet presented to the block
    cam_pose_t pose_expect_q [$];  // poses predicted but not yet received

    int  n_queued   = 0;
    int  n_taken    = 0;
    int  err_cnt    = 0;
    int  stall_cnt  = 0;
    logic cmd_taken = 1'b0;
    logic calm      = 1'b0;

    // ------------------------------------------------------------------
    // Camera model
    // ------------------------------------------------------------------

    // Sine and cosine of a 16-bit binary angle, floored to Q15. The angle is
    // folded into the right half plane first, and the result is negated back
    // when it was folded.
    function automatic void sin_cos(input logic [ANG_W-1:0] ang,
                                    output longint s15, output longint c15);
        longint     x;
        longint     y;
        longint     z;
        longint     xs;
        longint     ys;
        logic [31:0] u;
        logic       flip;
        u    = {ang, 16'h0000};
        flip = (u >= 32'h4000_0000) && (u < 32'hC000_0000);
        if (flip)
            u = u - 32'h8000_0000;
        z = longint'($signed(u));
        x = CORDIC_START;
        y = 0;
        for (int i = 0; i < N_ROT; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q32[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q32[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s15 = y >>> 15;
        c15 = x >>> 15;
    endfunction

    function automatic longint scale_q15(input longint move_dist, input longint f15);
        return (move_dist * f15) >>> 15;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_add(input logic signed [POS_W-1:0] p,
                                                          input longint d,
                                                          inout logic clipped);
        longint sum;
        sum = longint'(p) + d;
        if (sum > POS_HI)
        begin
            clipped = 1'b1;
            return POS_W'(POS_HI);
        end
        if (sum < POS_LO)
        begin
            clipped = 1'b1;
            return POS_W'(POS_LO);
        end
        return POS_W'(sum);
    endfunction

    // Applies one command to the model camera and returns the pose the block
    // should report for it.
    function automatic cam_pose_t advance_camera(input cam_cmd_t c);
        cam_pose_t        p;
        longint           move_dist;
        longint           sy;
        longint           cy;
        longint           sp;
        longint           cp;
        longint           dx;
        longint           dy;
        longint           dz;
        logic [ANG_W-1:0] turn;
        logic             clipped;
        // speed * time is Q12.20; position keeps 16 fraction bits.
        move_dist = (longint'(reg_move_speed) * longint'(c.time_step)) >>> 4;
        turn = ANG_W'((longint'(reg_turn_speed) * longint'(c.time_step)) >>> 20);
        sin_cos(cam_yaw, sy, cy);
        sin_cos(cam_pitch, sp, cp);
        dx = 0;
        dy = 0;
        dz = 0;
        clipped = 1'b0;
        case (c.command)
            CMD_LOAD:
            begin
                cam_x     = reg_start_x;
                cam_y     = reg_start_y;
                cam_z     = reg_start_z;
                cam_yaw   = reg_start_yaw;
                cam_pitch = reg_start_pitch;
            end
            CMD_LEFT:
            begin
                dx = -scale_q15(move_dist, cy);
                dz = scale_q15(move_dist, sy);
            end
            CMD_RIGHT:
            begin
                dx = scale_q15(move_dist, cy);
                dz = -scale_q15(move_dist, sy);
            end
            CMD_BACK:
            begin
                dx = scale_q15(move_dist, (sy * cp) >>> 15);
                dz = scale_q15(move_dist, (cy * cp) >>> 15);
                dy = -scale_q15(move_dist, sp);
            end
            CMD_FORWARD:
            begin
                dx = -scale_q15(move_dist, (sy * cp) >>> 15);
                dz = -scale_q15(move_dist, (cy * cp) >>> 15);
                dy = scale_q15(move_dist, sp);
            end
            CMD_DOWN:       dy = -move_dist;
            CMD_UP:         dy = move_dist;
            CMD_TURN_LEFT:  cam_yaw   = cam_yaw + turn;
            CMD_TURN_RIGHT: cam_yaw   = cam_yaw - turn;
            CMD_TURN_DOWN:  cam_pitch = cam_pitch - turn;
            CMD_TURN_UP:    cam_pitch = cam_pitch + turn;
            default:        ;
        endcase
        if (c.command >= CMD_LEFT && c.command <= CMD_UP)
        begin
            cam_x = clamp_add(cam_x, dx, clipped);
            cam_y = clamp_add(cam_y, dy, clipped);
            cam_z = clamp_add(cam_z, dz, clipped);
        end
        p.pos_x   = cam_x;
        p.pos_y   = cam_y;
        p.pos_z   = cam_z;
        p.yaw     = cam_yaw;
        p.pitch   = cam_pitch;
        p.clipped = clipped;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Channel activity
    // ------------------------------------------------------------------

    // True in the cycles in which a side holds back, unless in the calm phase.
    function automatic logic take_break();
        return !calm && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // Command driver. A transaction stays on the channel until it is taken;
    // only then, or from an empty channel, does the next one come up, and
    // then only if this cycle is not an idle one.
    always @(negedge clk)
    begin : drive_commands
        cam_cmd_t nxt;
        if (rst_n && (!cmd_ch.valid || cmd_taken))
        begin
            if (pending_q.size() != 0 && !take_break())
            begin
                nxt = pending_q.pop_front();
                cmd_ch.valid     <= 1'b1;
                cmd_ch.command   <= nxt.command;
                cmd_ch.time_step <= nxt.time_step;
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // The pose side stalls at random in the same proportion.
    always @(negedge clk)
    begin : drive_pose_ready
        if (rst_n)
            pose_ch.ready <= !take_break();
    end

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (got !== want)
        begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected 0x%h, got 0x%h",
                         $time, name, want, got);
        end
    endtask

    // Monitor. Every command transaction taken feeds the model, and every
    // pose transaction taken is held against the oldest prediction.
    always @(posedge clk)
    begin : watch_channels
        cam_cmd_t  c;
        cam_pose_t got;
        cam_pose_t want;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                c.command   = cmd_ch.command;
                c.time_step = cmd_ch.time_step;
                pose_expect_q.push_back(advance_camera(c));
                n_taken++;
            end
            if (pose_ch.valid && pose_ch.ready)
            begin
                got.pos_x   = pose_ch.pos_x_out;
                got.pos_y   = pose_ch.pos_y_out;
                got.pos_z   = pose_ch.pos_z_out;
                got.yaw     = pose_ch.yaw_out;
                got.pitch   = pose_ch.pitch_out;
                got.clipped = pose_ch.saturated;
                if (pose_expect_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t ns: unexpected pose, expected none, got %h",
                                 $time, got);
                end
                else
                begin
                    want = pose_expect_q.pop_front();
                    check_field("pos_x_out", want.pos_x, got.pos_x);
                    check_field("pos_y_out", want.pos_y, got.pos_y);
                    check_field("pos_z_out", want.pos_z, got.pos_z);
                    check_field("yaw_out", {16'h0, want.yaw}, {16'h0, got.yaw});
                    check_field("pitch_out", {16'h0, want.pitch}, {16'h0, got.pitch});
                    check_field("saturated", {31'h0, want.clipped}, {31'h0, got.clipped});
                end
            end
            cmd_taken <= cmd_ch.valid && cmd_ch.ready;
        end
    end

    // Watchdog: the run ends if no transaction and no register write happens
    // for too long.
    always @(posedge clk)
    begin : watchdog
        if ((cmd_ch.valid && cmd_ch.ready) || (pose_ch.valid && pose_ch.ready) || cfg_we)
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_cmd(input logic [CMD_W-1:0] command,
                             input logic [TIME_W-1:0] time_step);
        cam_cmd_t c;
        c.command   = command;
        c.time_step = time_step;
        pending_q.push_back(c);
        n_queued++;
    endtask

    // Returns once every queued command has been taken and every pose has
    // come back, so the block is idle and the registers may change.
    task automatic wait_drained();
        while (pending_q.size() != 0 || n_taken != n_queued || pose_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // Register write on the falling edge; the block takes it at the next
    // rising edge. The mirror follows at once since nothing is in flight.
    // Bits above a register's width are random and must be ignored.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_START_X:     reg_start_x     = val;
            CFG_START_Y:     reg_start_y     = val;
            CFG_START_Z:     reg_start_z     = val;
            CFG_START_PITCH: reg_start_pitch = val[15:0];
            CFG_START_YAW:   reg_start_yaw   = val[15:0];
            CFG_MOVE_SPEED:  reg_move_speed  = val[15:0];
            CFG_TURN_SPEED:  reg_turn_speed  = val[23:0];
            default:         ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Start coordinates: either extreme of the range, close to it so that
    // moves soon clip, anywhere, or near the origin.
    function automatic logic [31:0] pick_start();
        case ($urandom_range(4))
            0:       return 32'h7FFF_FFFF - $urandom_range(32'h0FFF_FFFF);
            1:       return 32'h8000_0000 + $urandom_range(32'h0FFF_FFFF);
            2:       return $urandom();
            3:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(32'h01FF_FFFF)) - 32'sh0100_0000);
        endcase
    endfunction

    // Register setting for one random phase. The first phase puts every
    // register at an extreme and the second at zero; the rest are random.
    task automatic configure_phase(input int ph);
        logic [15:0] move;
        logic [23:0] turn;
        case ($urandom_range(3))
            0:       move = '1;
            1:       move = 16'($urandom_range(16'h0400));
            default: move = 16'($urandom);
        endcase
        case ($urandom_range(3))
            0:       turn = '1;
            1:       turn = 24'($urandom_range(24'h020000));
            default: turn = 24'($urandom);
        endcase
        if (ph == 0)
        begin
            write_reg(CFG_START_X, 32'h7FFF_FFFF);
            write_reg(CFG_START_Y, 32'h8000_0000);
            write_reg(CFG_START_Z, 32'h8000_0000);
            write_reg(CFG_START_PITCH, {16'($urandom), 16'hFFFF});
            write_reg(CFG_START_YAW, {16'($urandom), 16'hFFFF});
            write_reg(CFG_MOVE_SPEED, {16'($urandom), 16'hFFFF});
            write_reg(CFG_TURN_SPEED, {8'($urandom), 24'hFF_FFFF});
        end
        else if (ph == 1)
        begin
            write_reg(CFG_START_X, 32'h0000_0000);
            write_reg(CFG_START_Y, 32'h0000_0000);
            write_reg(CFG_START_Z, 32'h0000_0000);
            write_reg(CFG_START_PITCH, {16'($urandom), 16'h0000});
            write_reg(CFG_START_YAW, {16'($urandom), 16'h0000});
            write_reg(CFG_MOVE_SPEED, {16'($urandom), 16'h0000});
            write_reg(CFG_TURN_SPEED, {8'($urandom), 24'h00_0000});
        end
        else
        begin
            write_reg(CFG_START_X, pick_start());
            write_reg(CFG_START_Y, pick_start());
            write_reg(CFG_START_Z, pick_start());
            write_reg(CFG_START_PITCH, $urandom());
            write_reg(CFG_START_YAW, $urandom());
            write_reg(CFG_MOVE_SPEED, {16'($urandom), move});
            write_reg(CFG_TURN_SPEED, {8'($urandom), turn});
        end
        end_writes();
    endtask

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return 16'($urandom_range(16'h1000));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly moves and turns, with a few loads and unused codes mixed in.
    function automatic logic [CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return CMD_LOAD;
        if (r < 8)
            return CMD_UNUSED_LO + 4'($urandom_range(CMD_UNUSED_HI - CMD_UNUSED_LO));
        if (r < 62)
            return CMD_LEFT + 4'($urandom_range(CMD_UP - CMD_LEFT));
        return CMD_TURN_LEFT + 4'($urandom_range(CMD_TURN_UP - CMD_TURN_LEFT));
    endfunction

    initial
    begin : stimulus
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = CMD_LOAD;
        cmd_ch.time_step = '0;
        pose_ch.ready    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset values: an unused code before anything else,
        // every move and turn, and the shortest and longest time steps.
        queue_cmd(CMD_UNUSED_HI, 16'hFFFF);
        queue_cmd(CMD_FORWARD, 16'hFFFF);
        queue_cmd(CMD_BACK, 16'h0000);
        queue_cmd(CMD_LEFT, 16'h1000);
        queue_cmd(CMD_RIGHT, 16'h8000);
        queue_cmd(CMD_UP, 16'hFFFF);
        queue_cmd(CMD_DOWN, 16'h0001);
        queue_cmd(CMD_TURN_LEFT, 16'hFFFF);
        queue_cmd(CMD_TURN_UP, 16'hFFFF);
        queue_cmd(CMD_FORWARD, 16'hFFFF);
        queue_cmd(CMD_TURN_RIGHT, 16'h1234);
        queue_cmd(CMD_TURN_DOWN, 16'hFFFF);
        queue_cmd(CMD_UNUSED_LO, 16'h0000);
        wait_drained();

        // Extreme registers: the load puts the camera on the edge of the
        // position range, so the following moves clip.
        write_reg(CFG_START_X, 32'h7FFF_FFFF);
        write_reg(CFG_START_Y, 32'h8000_0000);
        write_reg(CFG_START_Z, 32'h7FFF_0000);
        write_reg(CFG_START_PITCH, 32'h0000_FFFF);
        write_reg(CFG_START_YAW, 32'h0000_8000);
        write_reg(CFG_MOVE_SPEED, 32'h0000_FFFF);
        write_reg(CFG_TURN_SPEED, 32'h00FF_FFFF);
        end_writes();
        queue_cmd(CMD_LOAD, 16'h0000);
        queue_cmd(CMD_RIGHT, 16'hFFFF);
        queue_cmd(CMD_DOWN, 16'hFFFF);
        queue_cmd(CMD_UP, 16'hFFFF);
        queue_cmd(CMD_FORWARD, 16'hFFFF);
        queue_cmd(CMD_BACK, 16'hFFFF);
        queue_cmd(CMD_TURN_LEFT, 16'hFFFF);
        queue_cmd(CMD_LEFT, 16'hFFFF);
        queue_cmd(CMD_LOAD, 16'hFFFF);
        queue_cmd(CMD_UNUSED_HI, 16'h0000);
        wait_drained();

        // Random phases. Most start from a load so that the new start pose
        // is used, and one runs with neither side idling.
        for (int ph = 0; ph < N_RANDOM_PHASES; ph++)
        begin
            configure_phase(ph);
            calm = (ph == CALM_PHASE);
            if ($urandom_range(3) != 0)
                queue_cmd(CMD_LOAD, pick_time());
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_cmd(pick_command(), pick_time());
            wait_drained();
            calm = 1'b0;
        end

        // Give a stray extra pose time to show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
